// ----- hdl/p3ik_pkg.sv -----
// Shared types and constants for the planar three-link inverse kinematics block.
// Holds the datapath command set, the CORDIC arctangent table and the fixed-point constants.
// No dependencies.
package p3ik_pkg;

  localparam int LenW = 23;
  localparam int PosW = 24;
  localparam int AngW = 16;
  localparam int StepW = 5;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_UPPER = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FORE  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TOOL  = 2'd2;

  localparam logic [LenW-1:0] UPPER_RESET = 23'd19661;
  localparam logic [LenW-1:0] FORE_RESET  = 23'd19661;
  localparam logic [LenW-1:0] TOOL_RESET  = 23'd6554;

  localparam logic signed [19:0] PI_Q13     = 20'sd25736;
  localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [59:0] CORDIC_K_Q30 = 60'sd652032874;

  localparam logic [StepW-1:0] CORDIC_LAST = 5'd23;
  localparam logic [StepW-1:0] DIV_LAST    = 5'd30;
  localparam logic [StepW-1:0] SQRT_LAST   = 5'd30;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd13176795, 32'd7778716, 32'd4110060, 32'd2086331, 32'd1047214, 32'd524117,
    32'd262123, 32'd131069, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
    32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128,
    32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ROT,
    OP_SC_SAVE,
    OP_MUL_CX,
    OP_WX,
    OP_WY,
    OP_SQY,
    OP_SQA,
    OP_SQB,
    OP_AB,
    OP_DEN,
    OP_DIV_INIT,
    OP_DIV,
    OP_MUL_QQ,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_SIGN,
    OP_VLOAD_E,
    OP_VLOAD_Z,
    OP_VLOAD_G,
    OP_VEC,
    OP_SAVE_E,
    OP_SAVE_Z,
    OP_SAVE_G,
    OP_MUL_BS,
    OP_MUL_BC,
    OP_GX,
    OP_FINISH,
    OP_FAIL
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [StepW-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic unreach;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- hdl/planar_three_link_inverse_kinematics.sv -----
// A reachable target passes through the shared CORDIC unit (four passes of 24 steps), the
// 31-step divider and the 31-step square root; an unreachable target stops after the reach
// check. A new target is taken only once the previous one is finished. A finished result
// waits in the output register while the next target is accepted and worked on. Synchronous
// reset restores the link lengths, clears the held wrist angle and empties the output.
module planar_three_link_inverse_kinematics import p3ik_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   target_valid,
  output logic                   target_stall,
  input  logic signed [PosW-1:0] target_x,
  input  logic signed [PosW-1:0] target_y,
  input  logic signed [AngW-1:0] target_heading,
  input  logic                   elbow_flip,
  output logic                   joint_valid,
  input  logic                   joint_stall,
  output logic signed [AngW-1:0] shoulder_angle,
  output logic signed [AngW-1:0] elbow_angle,
  output logic signed [AngW-1:0] wrist_angle,
  output logic                   reachable,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [LenW-1:0]        cfg_data
);

  // Link length registers. The user must make writes only while the block is idle; the block
  // does not enforce it. The port is always ready and an index past the last register is dropped.
  logic [LenW-1:0] upper_len, fore_len, tool_len;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       idle;
  logic       accept;

  assign cfg_ready = 1'b1;

  // A target transfer happens only while the controller sits idle; the
  // datapath captures the target fields on that same edge.
  assign target_stall = !idle;
  assign accept = target_valid && idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= UPPER_RESET;
      fore_len  <= FORE_RESET;
      tool_len  <= TOOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UPPER: upper_len <= cfg_data;
        REG_FORE:  fore_len  <= cfg_data;
        REG_TOOL:  tool_len  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The controller walks through the solution step by step: heading sine and
  // cosine, wrist point, law of cosines, reach check, division, square root,
  // then three arctangents before the joint angles are formed and wrapped.
  p3ik_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .status (status),
    .cmd    (cmd),
    .idle   (idle)
  );

  // The datapath holds the working registers, the output register and the
  // wrist angle that an unreachable target repeats.
  p3ik_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .target_x       (target_x),
    .target_y       (target_y),
    .target_heading (target_heading),
    .elbow_flip     (elbow_flip),
    .upper_len      (upper_len),
    .fore_len       (fore_len),
    .tool_len       (tool_len),
    .shoulder_angle (shoulder_angle),
    .elbow_angle    (elbow_angle),
    .wrist_angle    (wrist_angle),
    .reachable      (reachable),
    .joint_valid    (joint_valid),
    .joint_stall    (joint_stall)
  );

endmodule

// ----- hdl/p3ik_ctrl.sv -----
// Controller state machine for the inverse kinematics block.
// Sequences the datapath through CORDIC, division and square root. Depends on p3ik_pkg.
module p3ik_ctrl import p3ik_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       idle
);

  typedef enum logic [4:0] {
    S_IDLE, S_ROT, S_SC_SAVE, S_MUL_CX, S_WX, S_WY, S_SQY, S_SQA, S_SQB, S_AB,
    S_DEN, S_CHECK, S_DIV, S_MUL_QQ, S_SQRT_INIT, S_SQRT, S_SIGN, S_VLOAD,
    S_VEC, S_VSAVE, S_MUL_BS, S_MUL_BC, S_GX, S_DONE, S_FAIL
  } state_t;

  typedef enum logic [1:0] {V_E, V_Z, V_G} vsel_t;

  state_t           state;
  vsel_t            vsel;
  logic [StepW-1:0] step;

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd.step = step;
    case (state)
      S_IDLE:      cmd.op = accept ? OP_LOAD : OP_IDLE;
      S_ROT:       cmd.op = OP_ROT;
      S_SC_SAVE:   cmd.op = OP_SC_SAVE;
      S_MUL_CX:    cmd.op = OP_MUL_CX;
      S_WX:        cmd.op = OP_WX;
      S_WY:        cmd.op = OP_WY;
      S_SQY:       cmd.op = OP_SQY;
      S_SQA:       cmd.op = OP_SQA;
      S_SQB:       cmd.op = OP_SQB;
      S_AB:        cmd.op = OP_AB;
      S_DEN:       cmd.op = OP_DEN;
      S_CHECK:     cmd.op = status.unreach ? OP_IDLE : OP_DIV_INIT;
      S_DIV:       cmd.op = OP_DIV;
      S_MUL_QQ:    cmd.op = OP_MUL_QQ;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT;
      S_SIGN:      cmd.op = OP_SIGN;
      S_VLOAD: begin
        case (vsel)
          V_E:     cmd.op = OP_VLOAD_E;
          V_Z:     cmd.op = OP_VLOAD_Z;
          default: cmd.op = OP_VLOAD_G;
        endcase
      end
      S_VEC:       cmd.op = OP_VEC;
      S_VSAVE: begin
        case (vsel)
          V_E:     cmd.op = OP_SAVE_E;
          V_Z:     cmd.op = OP_SAVE_Z;
          default: cmd.op = OP_SAVE_G;
        endcase
      end
      S_MUL_BS:    cmd.op = OP_MUL_BS;
      S_MUL_BC:    cmd.op = OP_MUL_BC;
      S_GX:        cmd.op = OP_GX;
      S_DONE:      cmd.op = status.out_busy ? OP_IDLE : OP_FINISH;
      S_FAIL:      cmd.op = status.out_busy ? OP_IDLE : OP_FAIL;
      default:     cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vsel  <= V_E;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          step <= '0;
          if (accept) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          step <= step + 5'd1;
          if (step == CORDIC_LAST) begin
            step  <= '0;
            state <= S_SC_SAVE;
          end
        end
        S_SC_SAVE:   state <= S_MUL_CX;
        S_MUL_CX:    state <= S_WX;
        S_WX:        state <= S_WY;
        S_WY:        state <= S_SQY;
        S_SQY:       state <= S_SQA;
        S_SQA:       state <= S_SQB;
        S_SQB:       state <= S_AB;
        S_AB:        state <= S_DEN;
        S_DEN:       state <= S_CHECK;
        S_CHECK:     state <= status.unreach ? S_FAIL : S_DIV;
        S_DIV: begin
          step <= step + 5'd1;
          if (step == DIV_LAST) begin
            step  <= '0;
            state <= S_MUL_QQ;
          end
        end
        S_MUL_QQ:    state <= S_SQRT_INIT;
        S_SQRT_INIT: state <= S_SQRT;
        S_SQRT: begin
          step <= step + 5'd1;
          if (step == SQRT_LAST) begin
            step  <= '0;
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          vsel  <= V_E;
          state <= S_VLOAD;
        end
        S_VLOAD: begin
          step  <= '0;
          state <= S_VEC;
        end
        S_VEC: begin
          step <= step + 5'd1;
          if (step == CORDIC_LAST) begin
            step  <= '0;
            state <= S_VSAVE;
          end
        end
        S_VSAVE: begin
          case (vsel)
            V_E: begin
              vsel  <= V_Z;
              state <= S_VLOAD;
            end
            V_Z:     state <= S_MUL_BS;
            default: state <= S_DONE;
          endcase
        end
        S_MUL_BS:    state <= S_MUL_BC;
        S_MUL_BC:    state <= S_GX;
        S_GX: begin
          vsel  <= V_G;
          state <= S_VLOAD;
        end
        S_DONE, S_FAIL: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/p3ik_datapath.sv -----
// Datapath of the inverse kinematics block: shared CORDIC, multiplier, divider and root unit.
// Executes one command from the controller per cycle. Depends on p3ik_pkg.
module p3ik_datapath import p3ik_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic signed [PosW-1:0] target_x,
  input  logic signed [PosW-1:0] target_y,
  input  logic signed [AngW-1:0] target_heading,
  input  logic                   elbow_flip,
  input  logic [LenW-1:0]        upper_len,
  input  logic [LenW-1:0]        fore_len,
  input  logic [LenW-1:0]        tool_len,
  output logic signed [AngW-1:0] shoulder_angle,
  output logic signed [AngW-1:0] elbow_angle,
  output logic signed [AngW-1:0] wrist_angle,
  output logic                   reachable,
  output logic                   joint_valid,
  input  logic                   joint_stall
);

  function automatic logic signed [17:0] to_q13(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v + 32'sd1024;
    t = t >>> 11;
    return t[17:0];
  endfunction

  function automatic logic signed [19:0] wrap(input logic signed [19:0] v);
    logic signed [19:0] w;
    w = v;
    for (int i = 0; i < 4; i++) begin
      if (w > PI_Q13) begin
        w = w - TWO_PI_Q13;
      end else if (w <= -PI_Q13) begin
        w = w + TWO_PI_Q13;
      end
    end
    return w;
  endfunction

  logic signed [PosW-1:0] tx, ty;
  logic signed [AngW-1:0] hd;
  logic                   flip, neg, vzero;
  logic signed [59:0]     cx, cy;
  logic signed [31:0]     cz;
  logic signed [33:0]     cs, sn, cq, s;
  logic signed [67:0]     prod;
  logic signed [59:0]     wx46, wy46;
  logic signed [57:0]     acc;
  logic [47:0]            den;
  logic [48:0]            rq;
  logic [30:0]            q;
  logic [60:0]            sv;
  logic [61:0]            sres;
  logic [60:0]            sbit;
  logic signed [17:0]     e13, z13, g13;
  logic signed [AngW-1:0] held;

  logic signed [33:0] ma, mb;
  logic signed [59:0] xs, ys, vx_in, vy_in;
  logic signed [31:0] atan_v, ang, ang_f;
  logic [57:0]        mag;
  logic [48:0]        r2;
  logic [61:0]        sq_t;
  logic signed [19:0] sh_raw, wr_raw, sh_w, el_w, wr_w;

  assign status.out_busy = joint_valid && joint_stall;
  assign mag = acc[57] ? 58'(-acc) : 58'(acc);
  assign status.unreach = (den == '0) || (mag > {10'd0, den});

  assign xs = cx >>> cmd.step;
  assign ys = cy >>> cmd.step;
  assign atan_v = ATAN_TAB[cmd.step];
  assign ang = {{5{target_heading[15]}}, target_heading, 11'd0};
  assign r2 = (cmd.step == '0) ? rq : {rq[47:0], 1'b0};
  assign sq_t = sres + {1'b0, sbit};

  always_comb begin
    ang_f = ang;
    if (ang > HALF_PI_Q24) begin
      ang_f = ang - PI_Q24;
    end else if (ang < -HALF_PI_Q24) begin
      ang_f = ang + PI_Q24;
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_CX: begin
        ma = {11'd0, tool_len};
        mb = cs;
      end
      OP_WX: begin
        ma = {11'd0, tool_len};
        mb = sn;
      end
      OP_WY: begin
        ma = {{4{wx46[59]}}, wx46[59:30]};
        mb = ma;
      end
      OP_SQY: begin
        ma = {{4{wy46[59]}}, wy46[59:30]};
        mb = ma;
      end
      OP_SQA: begin
        ma = {11'd0, upper_len};
        mb = ma;
      end
      OP_SQB: begin
        ma = {11'd0, fore_len};
        mb = ma;
      end
      OP_AB: begin
        ma = {11'd0, upper_len};
        mb = {11'd0, fore_len};
      end
      OP_MUL_QQ: begin
        ma = {3'd0, q};
        mb = ma;
      end
      OP_MUL_BS: begin
        ma = {11'd0, fore_len};
        mb = s;
      end
      OP_MUL_BC: begin
        ma = {11'd0, fore_len};
        mb = cq;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_VLOAD_E: begin
        vy_in = 60'(s);
        vx_in = 60'(cq);
      end
      default: begin
        vy_in = wy46;
        vx_in = wx46;
      end
    endcase
  end

  always_comb begin
    sh_raw = 20'(z13) - 20'(g13);
    wr_raw = 20'(hd) - sh_raw - 20'(e13);
    sh_w = wrap(sh_raw);
    el_w = wrap(20'(e13));
    wr_w = wrap(wr_raw);
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.op)
      OP_LOAD: begin
        tx   <= target_x;
        ty   <= target_y;
        hd   <= target_heading;
        flip <= elbow_flip;
        neg  <= (ang > HALF_PI_Q24) || (ang < -HALF_PI_Q24);
        cx   <= CORDIC_K_Q30;
        cy   <= '0;
        cz   <= ang_f;
      end
      OP_ROT: begin
        if (!cz[31]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_v;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_v;
        end
      end
      OP_SC_SAVE: begin
        cs <= neg ? 34'(-cx) : 34'(cx);
        sn <= neg ? 34'(-cy) : 34'(cy);
      end
      OP_WX:  wx46 <= {{6{tx[23]}}, tx, 30'd0} - prod[59:0];
      OP_WY:  wy46 <= {{6{ty[23]}}, ty, 30'd0} - prod[59:0];
      OP_SQY: acc <= prod[57:0];
      OP_SQA: acc <= acc + prod[57:0];
      OP_SQB, OP_AB: acc <= acc - prod[57:0];
      OP_DEN: den <= {prod[46:0], 1'b0};
      OP_DIV_INIT: begin
        rq <= {1'b0, mag[47:0]};
        q  <= '0;
      end
      OP_DIV: begin
        if (r2 >= {1'b0, den}) begin
          rq <= r2 - {1'b0, den};
          q  <= {q[29:0], 1'b1};
        end else begin
          rq <= r2;
          q  <= {q[29:0], 1'b0};
        end
      end
      OP_SQRT_INIT: begin
        sv   <= (61'd1 << 60) - prod[60:0];
        sres <= '0;
        sbit <= 61'd1 << 60;
      end
      OP_SQRT: begin
        if ({1'b0, sv} >= sq_t) begin
          sv   <= sv - sq_t[60:0];
          sres <= (sres >> 1) + {1'b0, sbit};
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_SIGN: begin
        cq <= acc[57] ? -{3'd0, q} : {3'd0, q};
        s  <= flip ? -{3'd0, sres[30:0]} : {3'd0, sres[30:0]};
      end
      OP_VLOAD_E, OP_VLOAD_Z, OP_VLOAD_G: begin
        vzero <= (vx_in == '0) && (vy_in == '0);
        if (vx_in[59]) begin
          cz <= vy_in[59] ? -PI_Q24 : PI_Q24;
          cx <= -vx_in;
          cy <= -vy_in;
        end else begin
          cz <= '0;
          cx <= vx_in;
          cy <= vy_in;
        end
      end
      OP_VEC: begin
        if (!cy[59]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_v;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_v;
        end
      end
      OP_SAVE_E: e13 <= vzero ? '0 : to_q13(cz);
      OP_SAVE_Z: z13 <= vzero ? '0 : to_q13(cz);
      OP_SAVE_G: g13 <= vzero ? '0 : to_q13(cz);
      OP_MUL_BC: wy46 <= prod[59:0];
      OP_GX: wx46 <= prod[59:0] + {7'd0, upper_len, 30'd0};
      OP_FINISH: begin
        shoulder_angle <= sh_w[15:0];
        elbow_angle    <= el_w[15:0];
        wrist_angle    <= wr_w[15:0];
        reachable      <= 1'b1;
      end
      OP_FAIL: begin
        shoulder_angle <= '0;
        elbow_angle    <= '0;
        wrist_angle    <= held;
        reachable      <= 1'b0;
      end
      default: begin
      end
    endcase

    if (rst) begin
      held        <= '0;
      joint_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_FINISH) begin
        held <= wr_w[15:0];
      end
      if (cmd.op == OP_FINISH || cmd.op == OP_FAIL) begin
        joint_valid <= 1'b1;
      end else if (!joint_stall) begin
        joint_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/p3ik_checker.sv -----
// Port-level checks for the inverse kinematics block, bound to the top level.
// Depends on p3ik_pkg.
module p3ik_checker import p3ik_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   target_valid,
  input logic                   target_stall,
  input logic                   joint_valid,
  input logic                   joint_stall,
  input logic signed [AngW-1:0] shoulder_angle,
  input logic signed [AngW-1:0] elbow_angle,
  input logic signed [AngW-1:0] wrist_angle,
  input logic                   reachable
);

  localparam logic signed [AngW-1:0] PiQ13 = 16'sd25736;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    joint_valid && joint_stall |=> joint_valid && $stable(wrist_angle) && $stable(reachable))
    else $error("stalled result changed");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    joint_valid && !reachable |-> shoulder_angle == '0 && elbow_angle == '0)
    else $error("unreachable result with nonzero angles");

  a_wrapped: assert property (@(posedge clk) disable iff (rst)
    joint_valid && reachable |-> shoulder_angle > -PiQ13 && elbow_angle > -PiQ13 &&
      wrist_angle > -PiQ13 && shoulder_angle <= PiQ13 && elbow_angle <= PiQ13 &&
      wrist_angle <= PiQ13)
    else $error("angle outside wrap range");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    target_valid && !target_stall |=> target_stall)
    else $error("second target taken while busy");

endmodule

bind planar_three_link_inverse_kinematics p3ik_checker u_p3ik_checker (
  .clk            (clk),
  .rst            (rst),
  .target_valid   (target_valid),
  .target_stall   (target_stall),
  .joint_valid    (joint_valid),
  .joint_stall    (joint_stall),
  .shoulder_angle (shoulder_angle),
  .elbow_angle    (elbow_angle),
  .wrist_angle    (wrist_angle),
  .reachable      (reachable)
);

// ----- test/tb_planar_three_link_inverse_kinematics.sv -----
// Self-checking testbench for the planar three-link inverse kinematics block.
// Holds a joint angle scoreboard class with its own fixed-point solver; needs only p3ik_pkg and the RTL.
module tb_planar_three_link_inverse_kinematics;
  import p3ik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected set of joint angles, as the block must present it.
  typedef struct {
    logic signed [AngW-1:0] shoulder;
    logic signed [AngW-1:0] elbow;
    logic signed [AngW-1:0] wrist;
    logic                   reach;
  } joint_set_t;

  // The scoreboard keeps its own copy of the link lengths and of the held wrist angle. It
  // solves each accepted target and compares each returned joint set with the oldest solution.
  class joint_scoreboard;
    longint           upper_len;
    longint           fore_len;
    longint           tool_len;
    int               held_wrist;
    joint_set_t       pending_joints[$];
    int               errors;
    int               reach_count;
    int               miss_count;

    function new();
      upper_len = UPPER_RESET;
      fore_len = FORE_RESET;
      tool_len = TOOL_RESET;
      held_wrist = 0;
      errors = 0;
      reach_count = 0;
      miss_count = 0;
    endfunction

    function void set_length(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
      case (idx)
        REG_UPPER: upper_len = val;
        REG_FORE:  fore_len = val;
        REG_TOOL:  tool_len = val;
        default: ;
      endcase
    endfunction

    // Rotation mode CORDIC: cosine and sine in Q.30 of a Q.24 angle in [-pi/2, pi/2].
    function void rotate(longint ang, output longint cs, output longint sn);
      longint x, y, xs, ys;
      x = CORDIC_K_Q30;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (ang >= 0) begin
          x -= ys; y += xs; ang -= longint'(ATAN_TAB[i]);
        end else begin
          x += ys; y -= xs; ang += longint'(ATAN_TAB[i]);
        end
      end
      cs = x;
      sn = y;
    endfunction

    // Vectoring mode CORDIC: atan2(y, x) in Q.24.
    function longint arctan2(longint y, longint x);
      longint ang, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        ang = (y >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; ang += longint'(ATAN_TAB[i]);
        end else begin
          x -= ys; y += xs; ang -= longint'(ATAN_TAB[i]);
        end
      end
      return ang;
    endfunction

    function int round_q13(longint v24);
      return int'((v24 + 1024) >>> 11);
    endfunction

    function int wrap_pi(int v);
      while (v > PI_Q13 || v <= -PI_Q13) begin
        if (v > PI_Q13) v -= TWO_PI_Q13;
        else v += TWO_PI_Q13;
      end
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Solves one accepted target and queues the joint set that it must produce.
    function void note_target(logic signed [PosW-1:0] tx, logic signed [PosW-1:0] ty,
                              logic signed [AngW-1:0] hd, logic flip);
      longint ang, cs, sn, wx46, wy46, wx, wy, num, den, cq, sq, s;
      longint unsigned mag, r, q;
      bit folded;
      int e13, g13, z13, sh, wr;
      joint_set_t js;
      ang = longint'(hd) * 2048;
      folded = 0;
      if (ang > HALF_PI_Q24) begin
        ang -= PI_Q24; folded = 1;
      end else if (ang < -longint'(HALF_PI_Q24)) begin
        ang += PI_Q24; folded = 1;
      end
      rotate(ang, cs, sn);
      if (folded) begin
        cs = -cs; sn = -sn;
      end
      wx46 = longint'(tx) * (64'sd1 <<< 30) - tool_len * cs;
      wy46 = longint'(ty) * (64'sd1 <<< 30) - tool_len * sn;
      wx = wx46 >>> 30;
      wy = wy46 >>> 30;
      num = wx * wx + wy * wy - upper_len * upper_len - fore_len * fore_len;
      den = 2 * upper_len * fore_len;
      mag = (num < 0) ? -num : num;
      if (den == 0 || mag > den) begin
        // Out of the workspace: zero joints, the wrist keeps its last solution.
        js.shoulder = '0;
        js.elbow = '0;
        js.wrist = held_wrist[AngW-1:0];
        js.reach = 1'b0;
      end else begin
        r = mag;
        q = 0;
        if (r >= den) begin
          r -= den; q = 1;
        end
        for (int i = 0; i < 30; i++) begin
          r <<= 1;
          q <<= 1;
          if (r >= den) begin
            r -= den; q |= 1;
          end
        end
        cq = (num < 0) ? -longint'(q) : longint'(q);
        sq = longint'(int_sqrt((64'd1 << 60) - q * q));
        s = flip ? -sq : sq;
        e13 = round_q13(arctan2(s, cq));
        g13 = round_q13(arctan2(fore_len * s, fore_len * cq + upper_len * (64'sd1 <<< 30)));
        z13 = round_q13(arctan2(wy46, wx46));
        sh = z13 - g13;
        wr = int'(hd) - sh - e13;
        sh = wrap_pi(sh);
        e13 = wrap_pi(e13);
        wr = wrap_pi(wr);
        held_wrist = wr;
        js.shoulder = sh[AngW-1:0];
        js.elbow = e13[AngW-1:0];
        js.wrist = wr[AngW-1:0];
        js.reach = 1'b1;
      end
      pending_joints.push_back(js);
    endfunction

    function void check_joints(logic signed [AngW-1:0] sh, logic signed [AngW-1:0] el,
                               logic signed [AngW-1:0] wr, logic rc);
      joint_set_t js;
      if (pending_joints.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: joint transfer with no target pending: %0d %0d %0d %0b",
                   sh, el, wr, rc);
        return;
      end
      js = pending_joints.pop_front();
      if (js.reach) reach_count++;
      else miss_count++;
      if (sh !== js.shoulder || el !== js.elbow || wr !== js.wrist || rc !== js.reach) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected sh %0d el %0d wr %0d r %0b, got sh %0d el %0d wr %0d r %0b",
                   js.shoulder, js.elbow, js.wrist, js.reach, sh, el, wr, rc);
      end
    endfunction
  endclass

  localparam int RandomPerPhase = 190;
  localparam int NumPhases = 8;
  localparam int WatchdogLimit = 20000;
  localparam real PiReal = 3.14159265358979;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   target_valid = 1'b0;
  logic                   target_stall;
  logic signed [PosW-1:0] target_x = '0;
  logic signed [PosW-1:0] target_y = '0;
  logic signed [AngW-1:0] target_heading = '0;
  logic                   elbow_flip = 1'b0;
  logic                   joint_valid;
  logic                   joint_stall = 1'b0;
  logic signed [AngW-1:0] shoulder_angle;
  logic signed [AngW-1:0] elbow_angle;
  logic signed [AngW-1:0] wrist_angle;
  logic                   reachable;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxW-1:0]     cfg_index = '0;
  logic [LenW-1:0]        cfg_data = '0;

  // Percent chance per cycle that the target side idles or the joint side stalls.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int idle_cycles = 0;
  joint_scoreboard sb;

  planar_three_link_inverse_kinematics uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The monitor samples at the rising edge, so it sees the values that the block saw. A
  // waiting result can be taken on the same edge as the next target; targets are solved
  // first and the queue keeps the older solution at its head.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_length(cfg_index, cfg_data);
      if (target_valid && !target_stall)
        sb.note_target(target_x, target_y, target_heading, elbow_flip);
      if (joint_valid && !joint_stall)
        sb.check_joints(shoulder_angle, elbow_angle, wrist_angle, reachable);
    end
  end

  // The joint side stalls at random, at the rate that the current phase asks.
  always @(posedge clk) begin
    joint_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // The watchdog ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (target_valid && !target_stall) || (joint_valid && !joint_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout after %0d cycles with no transfer", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Writes one link length and holds the transfer until the block takes it. The caller
  // drops the valid after its last write, so writes can follow back to back.
  task automatic write_length(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Sends one target. Any idle gap comes first, so a valid that stays high for the next
  // target is never dropped and raised in the same step.
  task automatic send_target(logic signed [PosW-1:0] tx, logic signed [PosW-1:0] ty,
                             logic signed [AngW-1:0] hd, logic flip);
    if ($urandom_range(99) < sender_idle_pct) begin
      target_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    target_valid <= 1'b1;
    target_x <= tx;
    target_y <= ty;
    target_heading <= hd;
    elbow_flip <= flip;
    do @(posedge clk); while (target_stall);
  endtask

  // Waits until every queued solution has been returned, then lets the block settle so that
  // a register write finds it idle.
  task automatic drain();
    target_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_joints.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [PosW-1:0] to_pos(real meters);
    real v;
    v = meters * 65536.0;
    if (v > 8388607.0) v = 8388607.0;
    if (v < -8388608.0) v = -8388608.0;
    return PosW'($rtoi(v));
  endfunction

  function automatic logic signed [AngW-1:0] to_heading(real rad);
    while (rad > PiReal) rad -= 2.0 * PiReal;
    while (rad <= -PiReal) rad += 2.0 * PiReal;
    return AngW'($rtoi(rad * 8192.0));
  endfunction

  function automatic real rand_angle();
    return (real'($urandom_range(1000000)) / 1000000.0 * 2.0 - 1.0) * PiReal;
  endfunction

  // Extremes of every field, both elbow branches, the folded and stretched arm, the wrist
  // at the origin and on the negative x axis, and headings at and around the fold points.
  task automatic directed_targets();
    logic signed [PosW-1:0] reach_x;
    reach_x = to_pos(real'(sb.upper_len + sb.fore_len + sb.tool_len) / 65536.0);
    send_target(0, 0, 0, 1'b0);
    send_target(0, 0, 0, 1'b1);
    send_target(24'sh7FFFFF, 0, 0, 1'b0);
    send_target(-24'sh800000, 0, 0, 1'b1);
    send_target(0, 24'sh7FFFFF, 16'sh7FFF, 1'b0);
    send_target(0, -24'sh800000, -16'sh8000, 1'b1);
    send_target(-24'sh800000, -24'sh800000, 16'sh7FFF, 1'b0);
    send_target(reach_x, 0, 0, 1'b0);
    send_target(reach_x - 24'sd2, 0, 0, 1'b1);
    send_target(PosW'(sb.tool_len), 0, 0, 1'b0);
    send_target(-24'sd30000, 0, 16'sd25736, 1'b0);
    send_target(-24'sd30000, 0, -16'sd25736, 1'b1);
    send_target(24'sd20000, 24'sd20000, 16'sd12868, 1'b0);
    send_target(24'sd20000, -24'sd20000, -16'sd12868, 1'b1);
    send_target(24'sd10000, 24'sd30000, 16'sd12869, 1'b0);
    send_target(-24'sd10000, 24'sd30000, -16'sd12869, 1'b1);
  endtask

  // Mostly targets built from random joint angles, so most are reachable; some sit close to
  // the fully stretched or folded elbow, and the rest are raw random bit patterns.
  task automatic random_targets(int count);
    real a, b, c, t1, t2, t3, x, y;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_target(PosW'($urandom), PosW'($urandom), AngW'($urandom), 1'($urandom));
      end else begin
        a = real'(sb.upper_len) / 65536.0;
        b = real'(sb.fore_len) / 65536.0;
        c = real'(sb.tool_len) / 65536.0;
        t1 = rand_angle();
        t2 = rand_angle();
        t3 = rand_angle();
        if (pick < 30) t2 = ($urandom_range(1) ? 0.0 : PiReal) + t2 * 0.001;
        x = a * $cos(t1) + b * $cos(t1 + t2) + c * $cos(t1 + t2 + t3);
        y = a * $sin(t1) + b * $sin(t1 + t2) + c * $sin(t1 + t2 + t3);
        send_target(to_pos(x), to_pos(y), to_heading(t1 + t2 + t3), 1'(t2 < 0.0));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NumPhases; p++) begin
      // Rotate through no idling, a sluggish sender, a sluggish receiver and both.
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
      endcase
      // The first phase keeps the reset lengths; the next ones cover equal links with no
      // tool, the smallest links, the largest, and random shapes.
      case (p)
        0: ;
        1: begin
          write_length(REG_UPPER, 23'd19661);
          write_length(REG_FORE, 23'd19661);
          write_length(REG_TOOL, 23'd0);
        end
        2: begin
          write_length(REG_UPPER, 23'd1);
          write_length(REG_FORE, 23'd1);
          write_length(REG_TOOL, 23'd0);
        end
        3: begin
          write_length(REG_UPPER, 23'h7FFFFF);
          write_length(REG_FORE, 23'h7FFFFF);
          write_length(REG_TOOL, 23'h7FFFFF);
        end
        default: begin
          write_length(REG_UPPER, LenW'($urandom_range(400000, 1000)));
          write_length(REG_FORE, LenW'($urandom_range(400000, 1000)));
          write_length(REG_TOOL, LenW'($urandom_range(200000, 0)));
        end
      endcase
      cfg_valid <= 1'b0;
      if (p < 2) directed_targets();
      random_targets(RandomPerPhase);
      drain();
    end

    $display("Checked %0d reachable and %0d unreachable solutions over %0d link settings,",
             sb.reach_count, sb.miss_count, NumPhases);
    $display("with idle and stall gaps on both sides; %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.pending_joints.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
